// ===== rtl/plic_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plic_pkg: shared types and constants of the platform interrupt controller
// Register map offsets, configuration indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package plic_pkg;

	localparam int NUM_SOURCES_DEF  = 32;
	localparam int MAX_CONTEXTS_DEF = 8;

	localparam logic [31:0] PENDING_BASE   = 32'h0000_1000;
	localparam logic [31:0] ENABLE_BASE    = 32'h0000_2000;
	localparam logic [31:0] ENABLE_STRIDE  = 32'h0000_0080;
	localparam logic [31:0] CONTEXT_BASE   = 32'h0020_0000;
	localparam logic [31:0] CONTEXT_STRIDE = 32'h0000_1000;
	localparam logic [11:0] THRESH_OFFSET  = 12'h000;
	localparam logic [11:0] CLAIM_OFFSET   = 12'h004;
	localparam logic [31:0] BASE_RESET     = 32'h0c00_0000;
	localparam logic [3:0]  CONTEXTS_RESET = 4'd2;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_LEVEL = 2'd2;

	localparam logic CFG_BASE     = 1'b0;
	localparam logic CFG_CONTEXTS = 1'b1;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_PRIO,
		ACC_PEND,
		ACC_ENABLE,
		ACC_THRESH,
		ACC_CLAIM
	} acc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PRIO_WAIT,
		ST_CLAIM_SCAN,
		ST_CLAIM_APPLY,
		ST_IRQ_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic prio_latch;
		logic scan_start;
		logic claim_apply;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		acc_t acc;
		logic is_read;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/plic_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plic_req_if: request channel
// Valid/ready channel carrying one bus access or one level change.
// ----------------------------------------------------------------------------
interface plic_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] address;
	logic [31:0] write_data;
	logic [4:0]  source_id;
	logic        source_level;

	modport source (output valid, req_type, address, write_data, source_id, source_level,
		input ready);
	modport sink (input valid, req_type, address, write_data, source_id, source_level,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/plic_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plic_rsp_if: result channel
// Valid/ready channel carrying read data and the per-context interrupt lines.
// ----------------------------------------------------------------------------
interface plic_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [7:0]  irq_lines;

	modport source (output valid, read_data, irq_lines, input ready);
	modport sink (input valid, read_data, irq_lines, output ready);
endinterface
`default_nettype wire

// ===== rtl/platform_interrupt_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// platform_interrupt_controller: platform-level interrupt controller
// Request sequencer plus datapath with priority RAM and per-context scan lanes.
// ----------------------------------------------------------------------------
// Each request is a bus read, a bus write or a source level change; each one
// yields exactly one response with read data and one interrupt line per
// context (bit c for context c, contexts 0..7). The register map follows the
// usual layout: source priorities at the base, the pending word at 0x1000,
// one enable word per context from 0x2000 in steps of 0x80, and threshold and
// claim/complete per context from 0x200000 in steps of 0x1000. Requests are
// handled one at a time. A priority read passes through an extra wait state
// before its scan to latch the RAM data. The priority RAM has one read
// port, so the search walks the sources one per cycle, with every context
// compared in parallel lanes. A claim read walks the sources twice, once to
// pick the winner and once to refresh the interrupt lines. A new request is
// taken while the previous response still waits to be taken.
// ----------------------------------------------------------------------------
module platform_interrupt_controller #(
	parameter int NUM_SOURCES  = plic_pkg::NUM_SOURCES_DEF,
	parameter int MAX_CONTEXTS = plic_pkg::MAX_CONTEXTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	plic_req_if.sink         req,
	plic_rsp_if.source       rsp
);
	plic_pkg::cmd_t cmd;
	plic_pkg::sts_t sts;

	// sequence each request through execute and scan
	plic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold state, decode, scan and drive the response register
	plic_dp #(
		.NUM_SOURCES  (NUM_SOURCES),
		.MAX_CONTEXTS (MAX_CONTEXTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req.req_type),
		.address      (req.address),
		.write_data   (req.write_data),
		.source_id    (req.source_id),
		.source_level (req.source_level),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.read_data    (rsp.read_data),
		.irq_lines    (rsp.irq_lines)
	);

	// never overwrite a response that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("response loaded over a pending one");

	// sequencer phases are exclusive
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.exec, cmd.prio_latch, cmd.claim_apply, cmd.out_load}))
		else $error("overlapping sequencer commands");

	// an accepted request blocks the next one until its response is built
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

endmodule
`default_nettype wire

// ===== rtl/plic_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plic_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module plic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/plic_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plic_ctrl: request sequencer
// Steps each request through execute, optional claim scan and interrupt scan.
// ----------------------------------------------------------------------------
module plic_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire plic_pkg::sts_t sts,
	output plic_pkg::cmd_t      cmd
);
	plic_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plic_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			plic_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_nxt = plic_pkg::ST_EXEC;
				end
			end
			plic_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.is_read && sts.acc == plic_pkg::ACC_PRIO) begin
					state_nxt = plic_pkg::ST_PRIO_WAIT;
				end else if (sts.is_read && sts.acc == plic_pkg::ACC_CLAIM) begin
					cmd.scan_start = 1'b1;
					state_nxt      = plic_pkg::ST_CLAIM_SCAN;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = plic_pkg::ST_IRQ_SCAN;
				end
			end
			plic_pkg::ST_PRIO_WAIT: begin
				cmd.prio_latch = 1'b1;
				cmd.scan_start = 1'b1;
				state_nxt      = plic_pkg::ST_IRQ_SCAN;
			end
			plic_pkg::ST_CLAIM_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = plic_pkg::ST_CLAIM_APPLY;
				end
			end
			plic_pkg::ST_CLAIM_APPLY: begin
				cmd.claim_apply = 1'b1;
				cmd.scan_start  = 1'b1;
				state_nxt       = plic_pkg::ST_IRQ_SCAN;
			end
			plic_pkg::ST_IRQ_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = plic_pkg::ST_DONE;
				end
			end
			plic_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = plic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = plic_pkg::ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/plic_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plic_dp: register file, address decode and priority scan lanes
// Holds all controller state and walks the priority RAM one source a cycle.
// ----------------------------------------------------------------------------
module plic_dp #(
	parameter int NUM_SOURCES  = plic_pkg::NUM_SOURCES_DEF,
	parameter int MAX_CONTEXTS = plic_pkg::MAX_CONTEXTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire plic_pkg::cmd_t cmd,
	output plic_pkg::sts_t      sts,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [31:0]    cfg_wdata,
	input  wire logic [1:0]     req_type,
	input  wire logic [31:0]    address,
	input  wire logic [31:0]    write_data,
	input  wire logic [4:0]     source_id,
	input  wire logic           source_level,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output logic [31:0]         read_data,
	output logic [7:0]          irq_lines
);
	localparam int SW = $clog2(NUM_SOURCES);
	localparam int CW = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;
	localparam logic [31:0] PRIO_LIMIT = 32'(4 * NUM_SOURCES);
	localparam logic [SW-1:0] LAST_SRC = SW'(NUM_SOURCES - 1);

	// configuration
	logic [31:0] base_q;
	logic [3:0]  act_q;

	// captured request
	logic [1:0]  type_q;
	logic [31:0] addr_q;
	logic [31:0] data_q;
	logic [4:0]  src_q;
	logic        lvl_q;

	// architectural state
	logic [NUM_SOURCES-1:0] prio_vld_q;
	logic [NUM_SOURCES-1:0] level_q;
	logic [NUM_SOURCES-1:0] pend_q;
	logic [NUM_SOURCES-1:0] clm_q;
	logic [31:0]            en_q  [MAX_CONTEXTS];
	logic [31:0]            thr_q [MAX_CONTEXTS];

	// scan
	logic [SW-1:0] cnt_q;
	logic          issue_q;
	logic          v_s1;
	logic [SW-1:0] idx_s1;
	logic          vld_s1;
	logic [31:0]   best_q [MAX_CONTEXTS];
	logic [SW-1:0] win_q  [MAX_CONTEXTS];

	logic [31:0]   rd_q;

	// decode
	logic [31:0]   off, eoff, coff, ctx_full;
	logic [CW-1:0] ctx;
	logic [SW-1:0] slot;
	logic          ctx_ok;
	plic_pkg::acc_t acc;
	logic [31:0]   bus_rd;

	logic          ram_we;
	logic [SW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic [31:0]   prio_rd;

	assign off  = addr_q - base_q;
	assign eoff = off - plic_pkg::ENABLE_BASE;
	assign coff = off - plic_pkg::CONTEXT_BASE;
	assign slot = off[SW+1:2];

	always_comb begin
		acc      = plic_pkg::ACC_NONE;
		ctx_full = '0;
		if (off < PRIO_LIMIT) begin
			acc = plic_pkg::ACC_PRIO;
		end else if (off == plic_pkg::PENDING_BASE) begin
			acc = plic_pkg::ACC_PEND;
		end else if (off >= plic_pkg::ENABLE_BASE && off < plic_pkg::CONTEXT_BASE) begin
			ctx_full = {7'd0, eoff[31:7]};
			if (eoff[6:2] == 5'd0) begin
				acc = plic_pkg::ACC_ENABLE;
			end
		end else if (off >= plic_pkg::CONTEXT_BASE) begin
			ctx_full = {12'd0, coff[31:12]};
			if (coff[11:0] == plic_pkg::THRESH_OFFSET) begin
				acc = plic_pkg::ACC_THRESH;
			end else if (coff[11:0] == plic_pkg::CLAIM_OFFSET) begin
				acc = plic_pkg::ACC_CLAIM;
			end
		end
		ctx_ok = (ctx_full < {28'd0, act_q}) && (ctx_full < 32'(MAX_CONTEXTS));
		if (!ctx_ok && (acc == plic_pkg::ACC_ENABLE || acc == plic_pkg::ACC_THRESH
				|| acc == plic_pkg::ACC_CLAIM)) begin
			acc = plic_pkg::ACC_NONE;
		end
	end

	assign ctx = ctx_full[CW-1:0];

	always_comb begin
		case (acc)
			plic_pkg::ACC_PEND:   bus_rd = 32'(pend_q);
			plic_pkg::ACC_ENABLE: bus_rd = en_q[ctx];
			plic_pkg::ACC_THRESH: bus_rd = thr_q[ctx];
			default:              bus_rd = '0;
		endcase
	end

	assign sts.acc       = acc;
	assign sts.is_read   = (type_q == plic_pkg::REQ_READ);
	assign sts.scan_done = v_s1 && (idx_s1 == LAST_SRC);
	assign sts.out_free  = !rsp_valid || rsp_ready;

	// priority RAM: bus port in execute, scan counter otherwise
	assign ram_we    = cmd.exec && type_q == plic_pkg::REQ_WRITE && acc == plic_pkg::ACC_PRIO
		&& slot != '0;
	assign ram_raddr = cmd.exec ? slot : cnt_q;

	plic_ram #(.WIDTH(32), .DEPTH(NUM_SOURCES)) u_prio_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (data_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign prio_rd = vld_s1 ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= plic_pkg::BASE_RESET;
			act_q  <= plic_pkg::CONTEXTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				plic_pkg::CFG_BASE:     base_q <= cfg_wdata;
				plic_pkg::CFG_CONTEXTS: act_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q <= req_type;
			addr_q <= address;
			data_q <= write_data;
			src_q  <= source_id;
			lvl_q  <= source_level;
		end
		vld_s1 <= prio_vld_q[ram_raddr];
		idx_s1 <= cnt_q;
	end

	// state updates of execute and claim
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_vld_q <= '0;
			level_q    <= '0;
			pend_q     <= '0;
			clm_q      <= '0;
			for (int c = 0; c < MAX_CONTEXTS; c++) begin
				en_q[c]  <= '0;
				thr_q[c] <= '0;
			end
		end else begin
			if (ram_we) begin
				prio_vld_q[slot] <= 1'b1;
			end
			if (cmd.exec && type_q == plic_pkg::REQ_LEVEL && src_q != 5'd0
					&& 32'(src_q) < 32'(NUM_SOURCES)) begin
				level_q[src_q[SW-1:0]] <= lvl_q;
				pend_q[src_q[SW-1:0]]  <= lvl_q;
			end
			if (cmd.exec && type_q == plic_pkg::REQ_WRITE) begin
				case (acc)
					plic_pkg::ACC_ENABLE: en_q[ctx]  <= data_q;
					plic_pkg::ACC_THRESH: thr_q[ctx] <= data_q;
					plic_pkg::ACC_CLAIM: begin
						if (data_q != '0 && data_q < 32'(NUM_SOURCES)) begin
							clm_q[data_q[SW-1:0]]  <= 1'b0;
							pend_q[data_q[SW-1:0]] <= level_q[data_q[SW-1:0]];
						end
					end
					default: ;
				endcase
			end
			if (cmd.claim_apply && win_q[ctx] != '0) begin
				clm_q[win_q[ctx]] <= 1'b1;
			end
		end
	end

	// scan sequencer: issue sources 1..N-1, compare in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= issue_q && !cmd.exec;
			if (cmd.scan_start) begin
				cnt_q   <= SW'(1);
				issue_q <= 1'b1;
			end else if (issue_q) begin
				if (cnt_q == LAST_SRC) begin
					issue_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// one compare lane per context
	for (genvar c = 0; c < MAX_CONTEXTS; c++) begin : g_lane
		logic cand;
		assign cand = pend_q[idx_s1] && !clm_q[idx_s1] && en_q[c][idx_s1];
		always_ff @(posedge clk) begin
			if (cmd.scan_start) begin
				best_q[c] <= '0;
				win_q[c]  <= '0;
			end else if (v_s1 && cand && prio_rd > thr_q[c] && prio_rd > best_q[c]) begin
				best_q[c] <= prio_rd;
				win_q[c]  <= idx_s1;
			end
		end
	end

	logic [7:0] irq_nxt;
	for (genvar c = 0; c < 8; c++) begin : g_irq
		if (c < MAX_CONTEXTS) begin : g_on
			assign irq_nxt[c] = (win_q[c] != '0) && (4'(c) < act_q);
		end else begin : g_off
			assign irq_nxt[c] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q <= sts.is_read ? bus_rd : '0;
		end else if (cmd.prio_latch) begin
			rd_q <= prio_rd;
		end else if (cmd.claim_apply) begin
			rd_q <= 32'(win_q[ctx]);
		end
		if (cmd.out_load) begin
			read_data <= rd_q;
			irq_lines <= irq_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire
